>>> rtl/core/sms_pkg.sv
// ----------------------------------------------------------------------------
// sms_pkg
// Shared types and constants for the SMBus master/slave sequencer: request
// and response payloads, bus event codes and address/command constants.
// ----------------------------------------------------------------------------
`default_nettype none

package sms_pkg;

   // Bus event codes carried in the request action field
   localparam logic [3:0] ACT_WRITE_REQUEST = 4'd0;
   localparam logic [3:0] ACT_LOAD_BYTE     = 4'd1;
   localparam logic [3:0] ACT_START_SENT    = 4'd2;
   localparam logic [3:0] ACT_MASTER_SENT   = 4'd3;
   localparam logic [3:0] ACT_MASTER_RX     = 4'd4;
   localparam logic [3:0] ACT_SLAVE_ADDR    = 4'd5;
   localparam logic [3:0] ACT_SLAVE_RX      = 4'd6;
   localparam logic [3:0] ACT_SLAVE_STOP    = 4'd7;
   localparam logic [3:0] ACT_SLAVE_SENT    = 4'd8;
   localparam logic [3:0] ACT_SLAVE_TX_STOP = 4'd9;
   localparam logic [3:0] ACT_TIMEOUT       = 4'd10;
   localparam logic [3:0] ACT_DATA_CONSUMED = 4'd11;

   // Slave command nibbles (high nibble of the write address)
   localparam logic [3:0] CMD_LONG_A = 4'h8;
   localparam logic [3:0] CMD_SHORT  = 4'h9;
   localparam logic [3:0] CMD_LONG_B = 4'hA;
   localparam logic [3:0] CMD_TINY   = 4'hB;

   // Address masks
   localparam logic [7:0] ADDR_MATCH_MASK = 8'hCE;
   localparam logic [7:0] ADDR_WRITE_MASK = 8'hFE;
   localparam logic [7:0] ADDR_HOLD_MASK  = 8'h30;
   localparam logic [7:0] OWN_ADDR_RESET  = 8'h80;

   // Slave read snapshot length and short receive lengths
   localparam int SLAVE_TX_BYTES = 5;
   localparam int RX_LEN_SHORT   = 4;
   localparam int RX_LEN_TINY    = 3;

   typedef struct packed {
      logic [3:0]  action;
      logic [7:0]  bus_byte;
      logic        ack_in;
      logic        arb_lost;
      logic [7:0]  target_address;
      logic [2:0]  byte_count;
      logic [2:0]  load_index;
      logic [7:0]  active_button;
      logic [15:0] point_x;
      logic [15:0] point_y;
   } req_type;

   typedef struct packed {
      logic [7:0] tx_byte;
      logic       tx_load;
      logic       ack_out;
      logic       start_out;
      logic       stop_out;
      logic       bus_reset;
      logic       busy_res;
      logic       slave_active;
      logic       rx_pending;
      logic [3:0] command;
      logic [3:0] rx_index;
      logic       rx_valid;
   } rsp_type;

endpackage

`default_nettype wire

>>> rtl/core/sms_req_reg.sv
// ----------------------------------------------------------------------------
// sms_req_reg
// Input register for bus event requests; takes a new request whenever it is
// empty or its held request moves on in the same cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module sms_req_reg (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             in_valid,
   output logic                  in_ready,
   input  wire sms_pkg::req_type in_data,
   output logic                  out_valid,
   input  wire logic             out_ready,
   output sms_pkg::req_type      out_data
);
   import sms_pkg::*;

   logic    valid_ff;
   logic    valid_in;
   req_type data_ff;

   assign in_ready  = !valid_ff || out_ready;
   assign valid_in  = in_valid || (valid_ff && !out_ready);
   assign out_valid = valid_ff;
   assign out_data  = data_ff;

   // Hold control state
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= valid_in;
      end
   end

   // Capture payload on accept
   always_ff @(posedge clock) begin
      if (in_valid && in_ready) begin
         data_ff <= in_data;
      end
   end

endmodule

`default_nettype wire

>>> rtl/core/sms_rsp_reg.sv
// ----------------------------------------------------------------------------
// sms_rsp_reg
// Result register; a finished response waits here while the next request is
// already being processed upstream.
// ----------------------------------------------------------------------------
`default_nettype none

module sms_rsp_reg (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             in_valid,
   output logic                  in_ready,
   input  wire sms_pkg::rsp_type in_data,
   output logic                  out_valid,
   input  wire logic             out_ready,
   output sms_pkg::rsp_type      out_data
);
   import sms_pkg::*;

   logic    valid_ff;
   rsp_type data_ff;

   assign in_ready  = !valid_ff || out_ready;
   assign out_valid = valid_ff;
   assign out_data  = data_ff;

   // Advance when empty or drained
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   // Capture result on advance
   always_ff @(posedge clock) begin
      if (in_valid && in_ready) begin
         data_ff <= in_data;
      end
   end

endmodule

`default_nettype wire

>>> rtl/core/sms_core.sv
// ----------------------------------------------------------------------------
// sms_core
// Sequencer state and one-step decode: applies one bus event to the master
// and slave state and forms the response combinationally.
// ----------------------------------------------------------------------------
`default_nettype none

module sms_core #(
   parameter int MASTER_BYTES   = 5,
   parameter int SLAVE_RX_BYTES = 12
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             csr_valid,
   input  wire logic [7:0]       csr_data,
   input  wire logic             in_valid,
   output logic                  in_ready,
   input  wire sms_pkg::req_type in_data,
   output logic                  out_valid,
   input  wire logic             out_ready,
   output sms_pkg::rsp_type      out_data
);
   import sms_pkg::*;

   localparam int MSW = $clog2(MASTER_BYTES + 1);
   localparam int MIW = (MASTER_BYTES > 1) ? $clog2(MASTER_BYTES) : 1;
   localparam int SRW = $clog2(SLAVE_RX_BYTES + 1);

   logic [7:0]     master_buffer_ff [MASTER_BYTES];
   logic [7:0]     master_buffer_in [MASTER_BYTES];
   logic [7:0]     slave_buffer_ff  [SLAVE_TX_BYTES];
   logic [7:0]     slave_buffer_in  [SLAVE_TX_BYTES];
   logic [7:0]     target_ff,      target_in;
   logic [MSW-1:0] write_len_ff,   write_len_in;
   logic [MSW-1:0] master_sent_ff, master_sent_in;
   logic [SRW-1:0] rx_len_ff,      rx_len_in;
   logic [SRW-1:0] rx_count_ff,    rx_count_in;
   logic [2:0]     tx_len_ff,      tx_len_in;
   logic [2:0]     tx_count_ff,    tx_count_in;
   logic           busy_ff,        busy_in;
   logic           slave_ff,       slave_in;
   logic           ready_ff,       ready_in;
   logic [3:0]     command_ff,     command_in;
   logic           arb_flag_ff,    arb_flag_in;
   logic [7:0]     own_addr_ff;
   logic           fire;
   logic           fail;
   logic [MIW-1:0] load_idx;
   logic [MIW-1:0] send_idx;
   rsp_type        rsp;

   assign in_ready  = out_ready;
   assign fire      = in_valid && out_ready;
   assign out_valid = in_valid;
   assign out_data  = rsp;
   assign load_idx  = MIW'(in_data.load_index);
   assign send_idx  = MIW'(master_sent_ff);

   // Decode one bus event
   always_comb begin
      master_buffer_in = master_buffer_ff;
      slave_buffer_in  = slave_buffer_ff;
      target_in        = target_ff;
      write_len_in     = write_len_ff;
      master_sent_in   = master_sent_ff;
      rx_len_in        = rx_len_ff;
      rx_count_in      = rx_count_ff;
      tx_len_in        = tx_len_ff;
      tx_count_in      = tx_count_ff;
      busy_in          = busy_ff;
      slave_in         = slave_ff;
      ready_in         = ready_ff;
      command_in       = command_ff;
      arb_flag_in      = arb_flag_ff;
      rsp              = '0;
      fail             = 1'b0;

      unique case (in_data.action)
         ACT_WRITE_REQUEST: begin
            if (!busy_ff && !slave_ff && !ready_ff) begin
               busy_in   = 1'b1;
               target_in = in_data.target_address;
               if (32'(in_data.byte_count) > MASTER_BYTES) begin
                  write_len_in = MSW'(MASTER_BYTES);
               end else begin
                  write_len_in = MSW'(in_data.byte_count);
               end
               rsp.start_out = 1'b1;
            end
         end
         ACT_LOAD_BYTE: begin
            if (32'(in_data.load_index) < MASTER_BYTES) begin
               master_buffer_in[load_idx] = in_data.bus_byte;
            end
         end
         ACT_START_SENT: begin
            rsp.tx_byte    = target_ff & ADDR_WRITE_MASK;
            rsp.tx_load    = 1'b1;
            master_sent_in = '0;
         end
         ACT_MASTER_SENT: begin
            if (in_data.arb_lost) begin
               fail = 1'b1;
            end else if (in_data.ack_in && master_sent_ff < write_len_ff &&
                         32'(master_sent_ff) < MASTER_BYTES) begin
               rsp.tx_byte    = master_buffer_ff[send_idx];
               rsp.tx_load    = 1'b1;
               master_sent_in = master_sent_ff + 1'b1;
            end else begin
               rsp.stop_out = 1'b1;
               busy_in      = 1'b0;
            end
         end
         ACT_SLAVE_ADDR: begin
            if (in_data.arb_lost) begin
               arb_flag_in = 1'b1;
            end
            rx_count_in = '0;
            tx_count_in = '0;
            if ((in_data.bus_byte & ADDR_MATCH_MASK) == (own_addr_ff & ADDR_MATCH_MASK)) begin
               slave_in = 1'b1;
               busy_in  = 1'b0;
               if (in_data.bus_byte[0]) begin
                  // Read: snapshot button and point unless the hold bits are set
                  if ((in_data.bus_byte & ADDR_HOLD_MASK) == 8'd0) begin
                     tx_len_in          = 3'(SLAVE_TX_BYTES);
                     slave_buffer_in[0] = in_data.active_button;
                     slave_buffer_in[1] = in_data.point_x[15:8];
                     slave_buffer_in[2] = in_data.point_x[7:0];
                     slave_buffer_in[3] = in_data.point_y[15:8];
                     slave_buffer_in[4] = in_data.point_y[7:0];
                     rsp.tx_byte        = in_data.active_button;
                  end else begin
                     rsp.tx_byte = slave_buffer_ff[0];
                  end
                  rsp.tx_load = 1'b1;
                  rsp.ack_out = 1'b1;
                  tx_count_in = 3'd1;
               end else if (!ready_ff) begin
                  // Write: take command and expected length
                  command_in = in_data.bus_byte[7:4];
                  unique case (in_data.bus_byte[7:4])
                     CMD_LONG_A: rx_len_in = SRW'(SLAVE_RX_BYTES);
                     CMD_SHORT:  rx_len_in = SRW'(RX_LEN_SHORT);
                     CMD_LONG_B: rx_len_in = SRW'(SLAVE_RX_BYTES);
                     CMD_TINY:   rx_len_in = SRW'(RX_LEN_TINY);
                     default:    rx_len_in = rx_len_ff;
                  endcase
                  rsp.ack_out = 1'b1;
               end
            end
         end
         ACT_SLAVE_RX: begin
            if (!in_data.arb_lost) begin
               if (32'(rx_count_ff) < SLAVE_RX_BYTES) begin
                  rsp.tx_byte  = in_data.bus_byte;
                  rsp.rx_index = 4'(rx_count_ff);
                  rsp.rx_valid = 1'b1;
                  rx_count_in  = rx_count_ff + 1'b1;
               end
               if (rx_count_in >= rx_len_ff) begin
                  ready_in = 1'b1;
                  slave_in = 1'b0;
               end
               rsp.ack_out = 1'b1;
            end
         end
         ACT_SLAVE_STOP: begin
            if (arb_flag_ff) begin
               rsp.start_out = 1'b1;
               arb_flag_in   = 1'b0;
            end
         end
         ACT_SLAVE_SENT: begin
            if (in_data.ack_in) begin
               if (tx_count_ff < tx_len_ff && 32'(tx_count_ff) < SLAVE_TX_BYTES) begin
                  rsp.tx_byte = slave_buffer_ff[tx_count_ff];
                  rsp.tx_load = 1'b1;
                  tx_count_in = tx_count_ff + 3'd1;
               end else begin
                  slave_in = 1'b0;
               end
            end
         end
         ACT_SLAVE_TX_STOP: begin
            rsp.tx_load = 1'b0;
         end
         ACT_TIMEOUT: begin
            rsp.bus_reset = 1'b1;
            busy_in       = 1'b0;
            slave_in      = 1'b0;
         end
         ACT_DATA_CONSUMED: begin
            ready_in = 1'b0;
         end
         default: begin
            fail = 1'b1;
         end
      endcase

      // Drop the bus on a failure
      if (fail) begin
         rsp.bus_reset = 1'b1;
         rsp.ack_out   = 1'b0;
         rsp.start_out = 1'b0;
         rsp.stop_out  = 1'b0;
         busy_in       = 1'b0;
         slave_in      = 1'b0;
      end

      rsp.busy_res     = busy_in;
      rsp.slave_active = slave_in;
      rsp.rx_pending   = ready_in;
      rsp.command      = command_in;
   end

   // Hold slave address register
   always_ff @(posedge clock) begin
      if (reset) begin
         own_addr_ff <= OWN_ADDR_RESET;
      end else if (csr_valid) begin
         own_addr_ff <= csr_data;
      end
   end

   // Advance sequencer state on each request
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < MASTER_BYTES; i++) begin
            master_buffer_ff[i] <= '0;
         end
         for (int i = 0; i < SLAVE_TX_BYTES; i++) begin
            slave_buffer_ff[i] <= '0;
         end
         target_ff      <= '0;
         write_len_ff   <= '0;
         master_sent_ff <= '0;
         rx_len_ff      <= '0;
         rx_count_ff    <= '0;
         tx_len_ff      <= '0;
         tx_count_ff    <= '0;
         busy_ff        <= 1'b0;
         slave_ff       <= 1'b0;
         ready_ff       <= 1'b0;
         command_ff     <= '0;
         arb_flag_ff    <= 1'b0;
      end else if (fire) begin
         master_buffer_ff <= master_buffer_in;
         slave_buffer_ff  <= slave_buffer_in;
         target_ff        <= target_in;
         write_len_ff     <= write_len_in;
         master_sent_ff   <= master_sent_in;
         rx_len_ff        <= rx_len_in;
         rx_count_ff      <= rx_count_in;
         tx_len_ff        <= tx_len_in;
         tx_count_ff      <= tx_count_in;
         busy_ff          <= busy_in;
         slave_ff         <= slave_in;
         ready_ff         <= ready_in;
         command_ff       <= command_in;
         arb_flag_ff      <= arb_flag_in;
      end
   end

endmodule

`default_nettype wire

>>> rtl/core/smbus_master_slave_sequencer.sv
// ----------------------------------------------------------------------------
// smbus_master_slave_sequencer
// Byte-level SMBus master/slave sequencer: one bus event request in, one
// bus drive response out.
// ----------------------------------------------------------------------------
//   channel   ports                          direction  moves
//   req       req_valid/req_ready/req_data   in         one bus event
//   rsp       rsp_valid/rsp_ready/rsp_data   out        one bus drive response
//   csr       csr_valid/csr_ready/csr_data   in         own slave address
//
// One request per cycle sustained while rsp_ready holds high; a request passes
// the input register, then the result register, before its response is offered.
// State is read and updated by combinational decode logic between the two.
// Synchronous reset clears core state and valid flags; own address returns to 0x80.
// rsp_ready low holds the result register and backs up into the input register.
// ----------------------------------------------------------------------------
`default_nettype none

module smbus_master_slave_sequencer #(
   parameter int MASTER_BYTES   = 5,
   parameter int SLAVE_RX_BYTES = 12
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_ready,
   input  wire sms_pkg::req_type req_data,
   output logic                  rsp_valid,
   input  wire logic             rsp_ready,
   output sms_pkg::rsp_type      rsp_data,
   input  wire logic             csr_valid,
   output logic                  csr_ready,
   input  wire logic [7:0]       csr_data
);
   import sms_pkg::*;

   logic    stg_valid;
   logic    stg_ready;
   req_type stg_data;
   logic    res_valid;
   logic    res_ready;
   rsp_type res_data;

   assign csr_ready = 1'b1;

   sms_req_reg u_req_reg (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_valid),
      .in_ready  (req_ready),
      .in_data   (req_data),
      .out_valid (stg_valid),
      .out_ready (stg_ready),
      .out_data  (stg_data)
   );

   sms_core #(
      .MASTER_BYTES   (MASTER_BYTES),
      .SLAVE_RX_BYTES (SLAVE_RX_BYTES)
   ) u_core (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_data  (csr_data),
      .in_valid  (stg_valid),
      .in_ready  (stg_ready),
      .in_data   (stg_data),
      .out_valid (res_valid),
      .out_ready (res_ready),
      .out_data  (res_data)
   );

   sms_rsp_reg u_rsp_reg (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (res_valid),
      .in_ready  (res_ready),
      .in_data   (res_data),
      .out_valid (rsp_valid),
      .out_ready (rsp_ready),
      .out_data  (rsp_data)
   );

endmodule

`default_nettype wire

>>> rtl/core/sms_checker.sv
// ----------------------------------------------------------------------------
// sms_checker
// Port-level checks for the SMBus sequencer, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module sms_checker (
   input wire logic             clock,
   input wire logic             reset,
   input wire logic             rsp_valid,
   input wire logic             rsp_ready,
   input wire sms_pkg::rsp_type rsp_data
);
   import sms_pkg::*;

   // Stalled response holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("stalled response changed");

   // Received byte report never loads the transmit register
   a_rx_no_load: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.rx_valid |-> !rsp_data.tx_load)
      else $error("rx report with tx load");

   // Bus reset drives no condition or acknowledge
   a_reset_quiet: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.bus_reset |->
         !rsp_data.start_out && !rsp_data.stop_out && !rsp_data.ack_out)
      else $error("bus reset with bus drive");

   // STOP always frees the bus
   a_stop_frees: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.stop_out |-> !rsp_data.busy_res)
      else $error("stop while busy");

   // Reset empties the response side
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid after reset");

endmodule

bind smbus_master_slave_sequencer sms_checker u_sms_checker (.*);

`default_nettype wire

>>> tb/sms_check_pkg.sv
// ----------------------------------------------------------------------------
// sms_check_pkg
// Scoreboard for the SMBus master/slave sequencer testbench. It keeps its
// own copy of the sequencer state, works out the bus drive that each
// accepted request should cause, and compares the drives that come back.
// ----------------------------------------------------------------------------
package sms_check_pkg;

   import sms_pkg::*;

   // Sizes of the block under its default parameters
   localparam int MASTER_SLOTS = 5;
   localparam int RX_BYTES_MAX = 12;

   class drive_scoreboard;

      // Predicted bus drives, oldest first
      rsp_type                        expected_drives[$];
      int unsigned                    mismatches;
      logic [7:0]                     own_addr;

      // Mirror of the sequencer state
      logic [MASTER_SLOTS-1:0][7:0]   master_buf;
      logic [SLAVE_TX_BYTES-1:0][7:0] snapshot_buf;
      logic [7:0]                     target;
      logic [2:0]                     write_len;
      logic [2:0]                     master_count;
      logic [3:0]                     rx_len;
      logic [3:0]                     rx_count;
      logic [2:0]                     tx_len;
      logic [2:0]                     tx_count;
      logic                           busy;
      logic                           slave;
      logic                           pending;
      logic [3:0]                     cmd;
      logic                           arb_seen;

      function new();
         mismatches   = 0;
         own_addr     = OWN_ADDR_RESET;
         master_buf   = '0;
         snapshot_buf = '0;
         target       = '0;
         write_len    = '0;
         master_count = '0;
         rx_len       = '0;
         rx_count     = '0;
         tx_len       = '0;
         tx_count     = '0;
         busy         = 1'b0;
         slave        = 1'b0;
         pending      = 1'b0;
         cmd          = '0;
         arb_seen     = 1'b0;
      endfunction

      function void set_own_address(input logic [7:0] value);
         own_addr = value;
      endfunction

      function int outstanding();
         return expected_drives.size();
      endfunction

      // Failure path: pulse the bus reset, drop the bus controls, free the bus
      function void abort_transfer(inout rsp_type o);
         o.bus_reset = 1'b1;
         o.ack_out   = 1'b0;
         o.start_out = 1'b0;
         o.stop_out  = 1'b0;
         busy        = 1'b0;
         slave       = 1'b0;
      endfunction

      // Work out the drive for one bus event and advance the mirror state
      function rsp_type predict_drive(input req_type r);
         rsp_type o;
         o = '0;
         case (r.action)
            ACT_WRITE_REQUEST: begin
               if (!busy && !slave && !pending) begin
                  busy      = 1'b1;
                  target    = r.target_address;
                  write_len = (r.byte_count > MASTER_SLOTS) ? 3'(MASTER_SLOTS) : r.byte_count;
                  o.start_out = 1'b1;
               end
            end
            ACT_LOAD_BYTE: begin
               if (r.load_index < MASTER_SLOTS)
                  master_buf[r.load_index] = r.bus_byte;
            end
            ACT_START_SENT: begin
               o.tx_byte    = target & ADDR_WRITE_MASK;
               o.tx_load    = 1'b1;
               master_count = '0;
            end
            ACT_MASTER_SENT: begin
               if (r.arb_lost) begin
                  abort_transfer(o);
               end else if (r.ack_in && master_count < write_len
                            && master_count < MASTER_SLOTS) begin
                  o.tx_byte    = master_buf[master_count];
                  o.tx_load    = 1'b1;
                  master_count = master_count + 3'd1;
               end else begin
                  // done or NACKed: stop and free the bus, no retry
                  o.stop_out = 1'b1;
                  busy       = 1'b0;
               end
            end
            ACT_SLAVE_ADDR: begin
               if (r.arb_lost)
                  arb_seen = 1'b1;
               rx_count = '0;
               tx_count = '0;
               if ((r.bus_byte & ADDR_MATCH_MASK) == (own_addr & ADDR_MATCH_MASK)) begin
                  slave = 1'b1;
                  busy  = 1'b0;
                  if (r.bus_byte[0]) begin
                     // read: take a fresh snapshot unless the hold bits are set
                     if ((r.bus_byte & ADDR_HOLD_MASK) == 8'h00) begin
                        tx_len          = 3'(SLAVE_TX_BYTES);
                        snapshot_buf[0] = r.active_button;
                        snapshot_buf[1] = r.point_x[15:8];
                        snapshot_buf[2] = r.point_x[7:0];
                        snapshot_buf[3] = r.point_y[15:8];
                        snapshot_buf[4] = r.point_y[7:0];
                     end
                     o.tx_byte = snapshot_buf[0];
                     o.tx_load = 1'b1;
                     o.ack_out = 1'b1;
                     tx_count  = 3'd1;
                  end else if (pending) begin
                     o.ack_out = 1'b0;
                  end else begin
                     cmd = r.bus_byte[7:4];
                     case (cmd)
                        CMD_LONG_A, CMD_LONG_B: rx_len = 4'(RX_BYTES_MAX);
                        CMD_SHORT:              rx_len = 4'(RX_LEN_SHORT);
                        CMD_TINY:               rx_len = 4'(RX_LEN_TINY);
                        default:                ;
                     endcase
                     o.ack_out = 1'b1;
                  end
               end
            end
            ACT_SLAVE_RX: begin
               if (!r.arb_lost) begin
                  if (rx_count < RX_BYTES_MAX) begin
                     o.tx_byte  = r.bus_byte;
                     o.rx_index = rx_count;
                     o.rx_valid = 1'b1;
                     rx_count   = rx_count + 4'd1;
                  end
                  if (rx_count >= rx_len) begin
                     pending = 1'b1;
                     slave   = 1'b0;
                  end
                  o.ack_out = 1'b1;
               end
            end
            ACT_SLAVE_STOP: begin
               if (arb_seen) begin
                  o.start_out = 1'b1;
                  arb_seen    = 1'b0;
               end
            end
            ACT_SLAVE_SENT: begin
               if (r.ack_in) begin
                  if (tx_count < tx_len && tx_count < SLAVE_TX_BYTES) begin
                     o.tx_byte = snapshot_buf[tx_count];
                     o.tx_load = 1'b1;
                     tx_count  = tx_count + 3'd1;
                  end else begin
                     slave = 1'b0;
                  end
               end
            end
            ACT_SLAVE_TX_STOP: ;
            ACT_TIMEOUT: begin
               o.bus_reset = 1'b1;
               busy        = 1'b0;
               slave       = 1'b0;
            end
            ACT_DATA_CONSUMED: pending = 1'b0;
            default: abort_transfer(o);
         endcase
         o.busy_res     = busy;
         o.slave_active = slave;
         o.rx_pending   = pending;
         o.command      = cmd;
         return o;
      endfunction

      function void note_event(input req_type r);
         expected_drives.push_back(predict_drive(r));
      endfunction

      function void compare_field(input string name, input logic [7:0] want,
                                  input logic [7:0] got);
         if (want !== got) begin
            $error("%s: expected %0h, actual %0h", name, want, got);
            mismatches++;
         end
      endfunction

      function void check_drive(input rsp_type got);
         rsp_type want;
         if (expected_drives.size() == 0) begin
            $error("response arrived with no request outstanding");
            mismatches++;
            return;
         end
         want = expected_drives.pop_front();
         compare_field("tx_byte",      want.tx_byte,      got.tx_byte);
         compare_field("tx_load",      want.tx_load,      got.tx_load);
         compare_field("ack_out",      want.ack_out,      got.ack_out);
         compare_field("start_out",    want.start_out,    got.start_out);
         compare_field("stop_out",     want.stop_out,     got.stop_out);
         compare_field("bus_reset",    want.bus_reset,    got.bus_reset);
         compare_field("busy_res",     want.busy_res,     got.busy_res);
         compare_field("slave_active", want.slave_active, got.slave_active);
         compare_field("rx_pending",   want.rx_pending,   got.rx_pending);
         compare_field("command",      want.command,      got.command);
         compare_field("rx_index",     want.rx_index,     got.rx_index);
         compare_field("rx_valid",     want.rx_valid,     got.rx_valid);
      endfunction

   endclass

endpackage

>>> tb/tb_smbus_master_slave_sequencer.sv
// ----------------------------------------------------------------------------
// tb_smbus_master_slave_sequencer
// Drives bus event requests into the sequencer: a short directed run over
// the corner cases, then phases of random master writes, slave reads, slave
// writes and noise under several own-address settings. Every response is
// checked field by field against the scoreboard's prediction.
// ----------------------------------------------------------------------------
module tb_smbus_master_slave_sequencer;

   timeunit 1ns;
   timeprecision 1ps;

   import sms_pkg::*;
   import sms_check_pkg::*;

   localparam int CLK_PERIOD     = 10;
   localparam int RESET_CYCLES   = 11;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int PHASES         = 8;
   localparam int PHASE_ITEMS    = 240;
   localparam int DRAIN_CYCLES   = 4;

   // Event codes outside the defined set
   localparam logic [3:0] ACT_UNDEFINED    = 4'd12;
   localparam logic [3:0] ACT_RESERVED_TOP = 4'd15;
   localparam logic [7:0] RW_READ_BIT      = 8'h01;

   typedef enum logic [1:0] {
      READY_ALWAYS,
      READY_COIN,
      READY_DUTY,
      READY_STALLS
   } ready_mode_type;

   logic       clock     = 1'b0;
   logic       reset     = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_ready;
   req_type    req_data  = '0;
   logic       rsp_valid;
   logic       rsp_ready = 1'b0;
   rsp_type    rsp_data;
   logic       csr_valid = 1'b0;
   logic       csr_ready;
   logic [7:0] csr_data  = '0;

   drive_scoreboard board = new();

   int unsigned    sent_count   = 0;
   int unsigned    burst_left   = 0;
   int unsigned    quiet_cycles = 0;
   ready_mode_type ready_mode   = READY_ALWAYS;
   int unsigned    mode_left    = 0;
   int unsigned    stall_left   = 0;
   int unsigned    duty_tick    = 0;

   smbus_master_slave_sequencer u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_data  (csr_data)
   );

   always #(CLK_PERIOD / 2) clock = ~clock;

   // Stall the response side on a pattern that changes mode now and then
   always @(posedge clock) begin
      logic next_ready;
      if (mode_left == 0) begin
         ready_mode = ready_mode_type'($urandom_range(0, 3));
         mode_left  = $urandom_range(50, 400);
      end
      mode_left--;
      duty_tick++;
      case (ready_mode)
         READY_ALWAYS: next_ready = 1'b1;
         READY_COIN:   next_ready = 1'($urandom_range(0, 1));
         READY_DUTY:   next_ready = (duty_tick % 3) != 0;
         default: begin
            if (stall_left != 0) begin
               next_ready = 1'b0;
               stall_left--;
            end else begin
               next_ready = 1'b1;
               if ($urandom_range(0, 7) == 0)
                  stall_left = $urandom_range(4, 24);
            end
         end
      endcase
      rsp_ready <= next_ready;
   end

   // Check responses, note requests and address writes; watch for a hang
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && rsp_ready)
            board.check_drive(rsp_data);
         if (req_valid && req_ready)
            board.note_event(req_data);
         if (csr_valid && csr_ready)
            board.set_own_address(csr_data);
         if ((rsp_valid && rsp_ready) || (req_valid && req_ready) || (csr_valid && csr_ready))
            quiet_cycles = 0;
         else
            quiet_cycles++;
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("FAIL");
            $finish;
         end
      end
   end

   function automatic req_type quiet_req(input logic [3:0] act);
      req_type r;
      r        = '0;
      r.action = act;
      return r;
   endfunction

   function automatic req_type random_req();
      logic [95:0] raw;
      req_type     r;
      raw = {$urandom, $urandom, $urandom};
      r   = raw[$bits(req_type)-1:0];
      return r;
   endfunction

   // Slave address byte that matches the current own address
   function automatic logic [7:0] own_match();
      return (board.own_addr & ADDR_MATCH_MASK) | (8'($urandom) & ~ADDR_MATCH_MASK);
   endfunction

   // Send one request; the sender runs in bursts with random gaps between
   task automatic issue(input req_type r);
      int unsigned gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
         if (gap != 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = $urandom_range(1, 40);
      end
      burst_left--;
      req_valid <= 1'b1;
      req_data  <= r;
      do @(posedge clock); while (!req_ready);
      sent_count++;
   endtask

   // Hold requests until every predicted drive has come back
   task automatic drain_drives();
      req_valid <= 1'b0;
      do @(posedge clock); while (board.outstanding() != 0);
      burst_left = 0;
   endtask

   task automatic write_own_address(input logic [7:0] value);
      csr_valid <= 1'b1;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
   endtask

   task automatic run_directed();
      req_type r;
      int unsigned k;
      // master buffer: extremes and a slot out of range
      r = quiet_req(ACT_LOAD_BYTE);
      r.load_index = 3'd0;
      r.bus_byte   = 8'hFF;
      issue(r);
      r.load_index = 3'd7;
      r.bus_byte   = 8'hAA;
      issue(r);
      // write request with a count that saturates, then one while busy
      r = quiet_req(ACT_WRITE_REQUEST);
      r.target_address = 8'hFF;
      r.byte_count     = 3'd7;
      issue(r);
      r.target_address = 8'h00;
      r.byte_count     = 3'd0;
      issue(r);
      issue(quiet_req(ACT_START_SENT));
      r = quiet_req(ACT_MASTER_SENT);
      r.ack_in = 1'b1;
      issue(r);
      // slave NACK ends the transfer
      r.ack_in = 1'b0;
      issue(r);
      // arbitration lost while master, then master receive
      r = quiet_req(ACT_WRITE_REQUEST);
      r.target_address = 8'h3C;
      r.byte_count     = 3'd2;
      issue(r);
      issue(quiet_req(ACT_START_SENT));
      r = quiet_req(ACT_MASTER_SENT);
      r.ack_in   = 1'b1;
      r.arb_lost = 1'b1;
      issue(r);
      issue(quiet_req(ACT_MASTER_RX));
      // slave read with arbitration lost on the address
      r = quiet_req(ACT_SLAVE_ADDR);
      r.bus_byte      = 8'h81;
      r.arb_lost      = 1'b1;
      r.active_button = 8'hFF;
      r.point_x       = 16'hFFFF;
      r.point_y       = 16'h0000;
      issue(r);
      r = quiet_req(ACT_SLAVE_SENT);
      r.ack_in = 1'b1;
      issue(r);
      r.ack_in = 1'b0;
      issue(r);
      // read with hold bits keeps the old snapshot
      r = quiet_req(ACT_SLAVE_ADDR);
      r.bus_byte = 8'hB1;
      r.point_x  = 16'h1234;
      issue(r);
      // stop after a lost arbitration reschedules a START
      issue(quiet_req(ACT_SLAVE_STOP));
      // tiny slave write
      r = quiet_req(ACT_SLAVE_ADDR);
      r.bus_byte = 8'hB0;
      issue(r);
      r = quiet_req(ACT_SLAVE_RX);
      for (k = 0; k < 3; k++) begin
         r.bus_byte = (k == 0) ? 8'hFF : 8'(k);
         issue(r);
      end
      // data pending: write request ignored, write address NACKed
      r = quiet_req(ACT_WRITE_REQUEST);
      r.byte_count = 3'd1;
      issue(r);
      r = quiet_req(ACT_SLAVE_ADDR);
      r.bus_byte = 8'h80;
      issue(r);
      r = quiet_req(ACT_SLAVE_RX);
      r.arb_lost = 1'b1;
      r.bus_byte = 8'h77;
      issue(r);
      issue(quiet_req(ACT_DATA_CONSUMED));
      r = quiet_req(ACT_SLAVE_ADDR);
      r.bus_byte = 8'h40;
      issue(r);
      issue(quiet_req(ACT_TIMEOUT));
      issue(quiet_req(ACT_UNDEFINED));
      issue(quiet_req(ACT_RESERVED_TOP));
   endtask

   // Mostly well-formed transfers with random content, some noise
   task automatic run_phase(input int unsigned quota);
      req_type     r;
      int unsigned first, n, k, len;
      first = sent_count;
      while (sent_count - first < quota) begin
         case ($urandom_range(0, 9))
            0, 1: begin
               // master write: load, request, START, address and data
               if ($urandom_range(0, 1) == 1) begin
                  r = random_req();
                  r.action = ACT_DATA_CONSUMED;
                  issue(r);
               end
               n = $urandom_range(0, 5);
               for (k = 0; k < n; k++) begin
                  r = random_req();
                  r.action     = ACT_LOAD_BYTE;
                  r.load_index = ($urandom_range(0, 9) == 0) ? 3'($urandom_range(5, 7))
                                                             : 3'($urandom_range(0, 4));
                  issue(r);
               end
               r = random_req();
               r.action     = ACT_WRITE_REQUEST;
               r.byte_count = ($urandom_range(0, 7) == 0) ? 3'($urandom_range(6, 7))
                                                          : 3'($urandom_range(0, 5));
               len = (r.byte_count > MASTER_SLOTS) ? MASTER_SLOTS : r.byte_count;
               issue(r);
               r = random_req();
               r.action = ACT_START_SENT;
               issue(r);
               for (k = 0; k <= len; k++) begin
                  r = random_req();
                  r.action   = ACT_MASTER_SENT;
                  r.ack_in   = ($urandom_range(0, 11) != 0);
                  r.arb_lost = ($urandom_range(0, 29) == 0);
                  issue(r);
                  if (!r.ack_in || r.arb_lost)
                     break;
               end
            end
            2, 3: begin
               // slave read: address, bytes sent, end of read
               r = random_req();
               r.action   = ACT_SLAVE_ADDR;
               r.bus_byte = own_match() | RW_READ_BIT;
               if ($urandom_range(0, 3) != 0)
                  r.bus_byte = r.bus_byte & ~ADDR_HOLD_MASK;
               if ($urandom_range(0, 11) == 0)
                  r.bus_byte = 8'($urandom);
               r.arb_lost = ($urandom_range(0, 9) == 0);
               issue(r);
               n = $urandom_range(0, 6);
               for (k = 0; k < n; k++) begin
                  r = random_req();
                  r.action = ACT_SLAVE_SENT;
                  r.ack_in = ($urandom_range(0, 7) != 0);
                  issue(r);
               end
               r = random_req();
               r.action = ($urandom_range(0, 1) == 1) ? ACT_SLAVE_TX_STOP : ACT_SLAVE_STOP;
               issue(r);
            end
            4, 5, 6: begin
               // slave write: address with command, received bytes, stop
               if ($urandom_range(0, 3) != 0) begin
                  r = random_req();
                  r.action = ACT_DATA_CONSUMED;
                  issue(r);
               end
               r = random_req();
               r.action   = ACT_SLAVE_ADDR;
               r.bus_byte = own_match() & ~RW_READ_BIT;
               if ($urandom_range(0, 11) == 0)
                  r.bus_byte = 8'($urandom);
               r.arb_lost = ($urandom_range(0, 11) == 0);
               issue(r);
               n = $urandom_range(1, 15);
               for (k = 0; k < n; k++) begin
                  r = random_req();
                  r.action   = ACT_SLAVE_RX;
                  r.arb_lost = ($urandom_range(0, 19) == 0);
                  issue(r);
               end
               r = random_req();
               r.action = ACT_SLAVE_STOP;
               issue(r);
            end
            7: begin
               // single disruptive event
               r = random_req();
               case ($urandom_range(0, 4))
                  0:       r.action = ACT_TIMEOUT;
                  1:       r.action = ACT_SLAVE_STOP;
                  2:       r.action = ACT_DATA_CONSUMED;
                  3:       r.action = ACT_UNDEFINED;
                  default: r.action = ACT_MASTER_RX;
               endcase
               issue(r);
            end
            default: begin
               // noise over the whole event field
               n = $urandom_range(1, 6);
               for (k = 0; k < n; k++)
                  issue(random_req());
            end
         endcase
      end
   endtask

   initial begin
      logic [7:0] own_plan [PHASES];
      int unsigned p;
      own_plan[0] = 8'hFF;
      own_plan[1] = 8'h00;
      own_plan[2] = 8'h80;
      own_plan[3] = 8'h4E;
      own_plan[4] = 8'hB1;
      own_plan[5] = 8'($urandom);
      own_plan[6] = 8'h80 | (8'($urandom) & 8'h3F);
      own_plan[7] = 8'h8E;

      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      run_directed();

      // each phase starts from an idle block with a new own address
      for (p = 0; p < PHASES; p++) begin
         drain_drives();
         repeat (DRAIN_CYCLES) @(posedge clock);
         write_own_address(own_plan[p]);
         run_phase(PHASE_ITEMS);
      end

      drain_drives();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (board.mismatches == 0)
         $display("PASS");
      else
         $display("FAIL");
      $finish;
   end

endmodule
